/* design/pfba_pkg.sv */
// Shared types and constants for the physical frame bitmap allocator.
// Used by pfba_bitmap_ram, pfba_ctrl and physical_frame_bitmap_allocator.
package pfba_pkg;

  localparam int NUM_FRAMES        = 65536;
  localparam int FIRST_SEARCH_WORD = 1;

  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int WORD_COUNT  = NUM_FRAMES / WORD_W;
  localparam int FRAME_LIMIT = WORD_COUNT * WORD_W;
  localparam int WADDR_W     = $clog2(WORD_COUNT);
  localparam int HINT_W      = $clog2(WORD_COUNT + 1);
  localparam int CNT_W       = $clog2(NUM_FRAMES + 1);

  localparam int CMD_W    = 2;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 17;

  localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_MARK_USED = 2'd1,
    CMD_MARK_FREE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } result_t;

endpackage

/* design/pfba_bitmap_ram.sv */
// Single-port-write, single-port-read bitmap memory with a registered read.
// Depends on pfba_pkg for the word width and depth.
module pfba_bitmap_ram import pfba_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [WADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0]  wr_data,
  input  logic               rd_en,
  input  logic [WADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0]  rd_data
);

  logic [WORD_W-1:0] mem [WORD_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/pfba_ctrl.sv */
// Command sequencer: clearing pass, word scan for allocate, read-modify-write
// for the mark commands, search hint and allocation count. Uses pfba_pkg.
module pfba_ctrl import pfba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [FRAME_W-1:0] frame,
  output logic               res_valid,
  input  logic               out_free,
  output result_t            res,
  output logic               wr_en,
  output logic [WADDR_W-1:0] wr_addr,
  output logic [WORD_W-1:0]  wr_data,
  output logic               rd_en,
  output logic [WADDR_W-1:0] rd_addr,
  input  logic [WORD_W-1:0]  rd_data
);

  state_t             state, state_next;
  logic [WADDR_W-1:0] clr_addr, clr_addr_next;
  logic [WADDR_W-1:0] waddr, waddr_next;
  logic [HINT_W-1:0]  hint, hint_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               is_free, is_free_next;
  logic [FRAME_W-1:0] res_frame, res_frame_next;
  status_t            res_status, res_status_next;

  logic [WADDR_W-1:0] frame_word;
  logic               frame_in_range;
  logic [BIT_W-1:0]   zero_bit;
  logic [WORD_W-1:0]  bit_mask;

  // Lowest clear bit of a word that is known not to be full.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

  assign frame_word     = WADDR_W'(frame >> BIT_W);
  assign frame_in_range = {16'd0, frame} < 32'(FRAME_LIMIT);
  assign zero_bit       = lowest_zero(rd_data);
  assign bit_mask       = {{(WORD_W-1){1'b0}}, 1'b1} << res_frame[BIT_W-1:0];

  assign res.frame  = res_frame;
  assign res.status = res_status;
  assign res.count  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      hint     <= HINT_W'(FIRST_SEARCH_WORD);
      count    <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      hint     <= hint_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    waddr      <= waddr_next;
    is_free    <= is_free_next;
    res_frame  <= res_frame_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    waddr_next      = waddr;
    hint_next       = hint;
    count_next      = count;
    is_free_next    = is_free;
    res_frame_next  = res_frame;
    res_status_next = res_status;
    in_stall        = 1'b1;
    res_valid       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = waddr;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = waddr;

    unique case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == WADDR_W'(WORD_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          res_frame_next  = frame;
          res_status_next = ST_DONE;
          is_free_next    = (cmd == CMD_MARK_FREE);
          unique case (cmd_t'(cmd))
            CMD_ALLOC: begin
              if (hint == HINT_W'(WORD_COUNT)) begin
                res_frame_next  = '0;
                res_status_next = ST_NO_FREE;
                state_next      = S_REPORT;
              end else begin
                waddr_next = WADDR_W'(hint);
                rd_en      = 1'b1;
                rd_addr    = WADDR_W'(hint);
                state_next = S_SCAN;
              end
            end
            CMD_MARK_USED, CMD_MARK_FREE: begin
              if (!frame_in_range) begin
                res_status_next = ST_RANGE;
                state_next      = S_REPORT;
              end else begin
                waddr_next = frame_word;
                rd_en      = 1'b1;
                rd_addr    = frame_word;
                state_next = S_MARK;
              end
            end
            default: begin
              state_next = S_REPORT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data != FULL_WORD) begin
          wr_en          = 1'b1;
          wr_data        = rd_data | ({{(WORD_W-1){1'b0}}, 1'b1} << zero_bit);
          hint_next      = HINT_W'(waddr);
          res_frame_next = FRAME_W'({waddr, zero_bit});
          if (count < CNT_W'(NUM_FRAMES)) begin
            count_next = count + 1'b1;
          end
          state_next = S_REPORT;
        end else if (waddr == WADDR_W'(WORD_COUNT - 1)) begin
          hint_next       = HINT_W'(WORD_COUNT);
          res_frame_next  = '0;
          res_status_next = ST_NO_FREE;
          state_next      = S_REPORT;
        end else begin
          waddr_next = waddr + 1'b1;
          rd_en      = 1'b1;
          rd_addr    = waddr + 1'b1;
        end
      end

      S_MARK: begin
        wr_en = 1'b1;
        if (is_free) begin
          wr_data = rd_data & ~bit_mask;
          if (count != '0) begin
            count_next = count - 1'b1;
          end
          // A freed frame in the searched range may lie below the hint.
          if ({1'b0, waddr} >= HINT_W'(FIRST_SEARCH_WORD) && HINT_W'(waddr) < hint) begin
            hint_next = HINT_W'(waddr);
          end
        end else begin
          wr_data = rd_data | bit_mask;
          if (count < CNT_W'(NUM_FRAMES)) begin
            count_next = count + 1'b1;
          end
        end
        state_next = S_REPORT;
      end

      S_REPORT: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/physical_frame_bitmap_allocator.sv */
// Top level of the physical frame bitmap allocator: sequencer, bitmap memory
// and the output register. Depends on pfba_pkg, pfba_ctrl and pfba_bitmap_ram.
//
// Usage: a command transfer carries cmd (allocate, mark used, mark free) and
// frame; every command produces exactly one result transfer with
// result_frame, status and used_count. Both channels use valid and stall.
// After reset the bitmap memory is cleared by a pass of one word per cycle
// over all 2048 words, during which in_stall stays high. The allocation count
// and the search hint reset at once.
// A mark command reads its word at the input transfer; in S_MARK the word is
// modified and written back, and in S_REPORT the result is handed to the
// output register, which then raises out_valid. The next command is taken
// only once the sequencer is back in S_IDLE. An allocate reads one word at a
// time through the single read port of the bitmap memory; the scan starts at
// a hint, the lowest word that may still hold a free frame, so it usually
// reads one word but can read up to 2047. A command that needs no memory
// access goes straight from S_IDLE to S_REPORT. Commands are worked on one
// at a time. A finished result sits in the output register; a new command
// is accepted while it waits, and when out_stall is held the sequencer
// keeps its next result until the register drains.
module physical_frame_bitmap_allocator import pfba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [FRAME_W-1:0]  frame,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FRAME_W-1:0]  result_frame,
  output logic [STATUS_W-1:0] status,
  output logic [USED_W-1:0]   used_count
);

  logic               res_valid;
  logic               out_free;
  result_t            res;
  result_t            out_q;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0]  rd_data;

  pfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .frame     (frame),
    .res_valid (res_valid),
    .out_free  (out_free),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  pfba_bitmap_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register can take a new result when it is empty or when its
  // current result is transferred in this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign result_frame = out_q.frame;
  assign status       = out_q.status;
  assign used_count   = USED_W'(out_q.count);

endmodule
